### rtl/assert_macros.svh
// Assertion helpers; the including module provides i_clk and i_rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define NPAG_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define NPAG_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/npag_pkg.sv
package npag_pkg;

    // Fixed field widths
    localparam int COORD_W   = 24;
    localparam int LAYER_W   = 4;
    localparam int OUT_IDX_W = 9;

    // Stream widths
    localparam int S_TDATA_W = 56;  // layer, coord_x, coord_y, pad
    localparam int S_TUSER_W = 2;   // command, first
    localparam int M_TDATA_W = 16;  // found, point_index, pad

    // Default sizing
    localparam int DEF_MAX_POINTS = 512;
    localparam int DEF_NUM_LAYERS = 16;

    // Command codes
    localparam logic CMD_LOAD  = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_LD_CNT,
        S_Q_CNT,
        S_SCAN,
        S_OUT
    } t_state;

endpackage

### rtl/nearest_point_with_angle_gate.sv
// Nearest point with angle gate. Points are loaded per layer (one item per
// point, tuser[1] restarts the layer) into a point RAM, and a query item
// returns the index of the nearest stored point of its layer whose polar
// angle is at or past the query's angle, found=0 if none qualifies. Each
// item is taken only when the block is idle. A load reads the count RAM,
// then writes the point and the count; a load to a full layer or to a
// layer >= NUM_LAYERS is dropped. A query scans its layer and then waits
// for the result to be taken: one point RAM read per cycle feeds a
// four-stage evaluate pipeline (difference, multiplies, sum and angle
// test, best-so-far compare), so the layer's point count sets the scan's
// length. Ties on squared distance keep the earlier index. No clearing
// pass is needed after reset: per-layer valid bits make every count read as
// zero until written.
// s tdata: [3:0] layer, [27:4] coord_x, [51:28] coord_y, [55:52] zero.
// s tuser: [0] command (0 load, 1 query), [1] first.
// m tdata: [0] found, [9:1] point_index, [15:10] zero.
`include "assert_macros.svh"

module nearest_point_with_angle_gate #(
    parameter int MAX_POINTS = npag_pkg::DEF_MAX_POINTS,
    parameter int NUM_LAYERS = npag_pkg::DEF_NUM_LAYERS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // input stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    input  logic [npag_pkg::S_TDATA_W-1:0] i_s_tdata,  // layer, coord_x, coord_y
    input  logic [npag_pkg::S_TUSER_W-1:0] i_s_tuser,  // command, first
    // result stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    output logic [npag_pkg::M_TDATA_W-1:0] o_m_tdata   // found, point_index
);

    localparam int IDX_W    = $clog2(MAX_POINTS);
    localparam int CNT_W    = $clog2(MAX_POINTS + 1);
    localparam int LA_W     = (NUM_LAYERS > 1) ? $clog2(NUM_LAYERS) : 1;
    localparam int PA_W     = LA_W + IDX_W;
    localparam int PT_DEPTH = NUM_LAYERS * (2 ** IDX_W);
    localparam int CW       = npag_pkg::COORD_W;
    localparam int LW       = npag_pkg::LAYER_W;
    localparam int OW       = npag_pkg::OUT_IDX_W;

    // ------------------------------------------------------------------
    // Input unpack
    // ------------------------------------------------------------------
    logic                 w_cmd, w_first, w_s_acc, w_lay_ok;
    logic [LW-1:0]        w_layer;
    logic signed [CW-1:0] w_x, w_y;
    logic [LA_W-1:0]      w_lay;

    assign w_cmd    = i_s_tuser[0];
    assign w_first  = i_s_tuser[1];
    assign w_layer  = i_s_tdata[LW-1:0];
    assign w_x      = i_s_tdata[LW +: CW];
    assign w_y      = i_s_tdata[LW+CW +: CW];
    assign w_lay    = LA_W'(w_layer);
    assign w_lay_ok = ({28'd0, w_layer} < 32'(NUM_LAYERS));
    assign w_s_acc  = i_s_tvalid && o_s_tready;

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    npag_pkg::t_state r_state, n_state;

    logic [LA_W-1:0]       r_lay;
    logic                  r_lay_ok, r_first;
    logic signed [CW-1:0]  r_qx, r_qy;
    logic                  r_qz, r_qposx, r_hq;
    logic [CNT_W-1:0]      r_cnt, r_idx;
    logic [NUM_LAYERS-1:0] r_cnt_vld;

    logic                  w_issue, w_pipe_busy;
    logic [CNT_W-1:0]      w_cnt_rd, w_ld_cnt;
    logic                  w_ld_we;

    // pipeline
    logic                  r_v0, r_v1, r_v2, r_v3;
    logic [IDX_W-1:0]      r_i0, r_i1, r_i2, r_i3;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            npag_pkg::S_IDLE: begin
                if (w_s_acc) begin
                    if (w_cmd == npag_pkg::CMD_QUERY) begin
                        n_state = npag_pkg::S_Q_CNT;
                    end else if (w_lay_ok) begin
                        n_state = npag_pkg::S_LD_CNT;
                    end
                end
            end
            npag_pkg::S_LD_CNT: n_state = npag_pkg::S_IDLE;
            npag_pkg::S_Q_CNT:  n_state = npag_pkg::S_SCAN;
            npag_pkg::S_SCAN: begin
                if (r_idx == r_cnt && !w_pipe_busy) begin
                    n_state = npag_pkg::S_OUT;
                end
            end
            npag_pkg::S_OUT: begin
                if (i_m_tready) begin
                    n_state = npag_pkg::S_IDLE;
                end
            end
            default: n_state = npag_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= npag_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_s_tready  = (r_state == npag_pkg::S_IDLE);
    assign w_issue     = (r_state == npag_pkg::S_SCAN) && (r_idx != r_cnt);
    assign w_pipe_busy = r_v0 || r_v1 || r_v2 || r_v3;

    // ------------------------------------------------------------------
    // Layer counts: RAM plus per-layer valid bits (unwritten reads as zero)
    // ------------------------------------------------------------------
    logic [CNT_W-1:0] w_cnt_q;

    assign w_cnt_rd = r_cnt_vld[r_lay] ? w_cnt_q : '0;
    assign w_ld_cnt = r_first ? '0 : w_cnt_rd;
    assign w_ld_we  = (r_state == npag_pkg::S_LD_CNT) && (w_ld_cnt < CNT_W'(MAX_POINTS));

    npag_ram #(
        .WIDTH(CNT_W),
        .DEPTH(NUM_LAYERS),
        .AW   (LA_W)
    ) u_cnt_ram (
        .i_clk  (i_clk),
        .i_we   (w_ld_we),
        .i_waddr(r_lay),
        .i_wdata(w_ld_cnt + CNT_W'(1)),
        .i_raddr(w_lay),
        .o_rdata(w_cnt_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt_vld <= '0;
        end else if (w_ld_we) begin
            r_cnt_vld[r_lay] <= 1'b1;
        end
    end

    // ------------------------------------------------------------------
    // Point store
    // ------------------------------------------------------------------
    logic [2*CW-1:0] w_pt_q;

    npag_ram #(
        .WIDTH(2 * CW),
        .DEPTH(PT_DEPTH),
        .AW   (PA_W)
    ) u_pt_ram (
        .i_clk  (i_clk),
        .i_we   (w_ld_we),
        .i_waddr({r_lay, w_ld_cnt[IDX_W-1:0]}),
        .i_wdata({r_qy, r_qx}),
        .i_raddr({r_lay, r_idx[IDX_W-1:0]}),
        .o_rdata(w_pt_q)
    );

    // ------------------------------------------------------------------
    // Item capture, query setup and scan index
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (w_s_acc) begin
            r_lay    <= w_lay;
            r_lay_ok <= w_lay_ok;
            r_first  <= w_first;
            r_qx     <= w_x;
            r_qy     <= w_y;
            r_qz     <= (w_x == '0) && (w_y == '0);
            r_qposx  <= (w_y == '0) && !w_x[CW-1] && (w_x != '0);
            // query half-plane: 0 for y > 0, or y = 0 with x >= 0
            r_hq     <= !((!w_y[CW-1] && w_y != '0) || (w_y == '0 && !w_x[CW-1]));
        end
        if (r_state == npag_pkg::S_Q_CNT) begin
            r_cnt <= r_lay_ok ? w_cnt_rd : '0;
            r_idx <= '0;
        end else if (w_issue) begin
            r_idx <= r_idx + CNT_W'(1);
        end
    end

    // ------------------------------------------------------------------
    // Evaluate pipeline, one point per cycle
    // ------------------------------------------------------------------
    logic signed [CW-1:0] w_px, w_py;
    assign w_px = w_pt_q[CW-1:0];
    assign w_py = w_pt_q[2*CW-1:CW];

    // stage A: differences and half-plane
    logic signed [CW:0]   r_dx, r_dy;
    logic signed [CW-1:0] r_px, r_py;
    logic                 r_pz1, r_hp1;

    // stage B: products
    logic signed [2*CW+1:0] w_dx2, w_dy2;
    logic signed [2*CW-1:0] w_c1, w_c2;
    logic [2*CW:0]          r_dx2, r_dy2;
    logic signed [2*CW-1:0] r_c1, r_c2;
    logic                   r_pz2, r_hp2;

    assign w_dx2 = r_dx * r_dx;
    assign w_dy2 = r_dy * r_dy;
    assign w_c1  = r_qx * r_py;
    assign w_c2  = r_qy * r_px;

    // stage C: distance and angle gate
    logic [2*CW+1:0]      w_d;
    logic signed [2*CW:0] w_cross;
    logic                 w_pass;
    logic [2*CW+1:0]      r_d3;
    logic                 r_pass3;

    assign w_d     = {1'b0, r_dx2} + {1'b0, r_dy2};
    assign w_cross = r_c1 - r_c2;
    assign w_pass  = r_qz || (r_pz2 ? r_qposx
                            : ((r_hp2 != r_hq) ? r_hp2 : !w_cross[2*CW]));

    // stage D: best so far
    logic                 r_found;
    logic [IDX_W-1:0]     r_best_idx;
    logic [2*CW+1:0]      r_best_d;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v0 <= w_issue;
            r_v1 <= r_v0;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    always_ff @(posedge i_clk) begin
        r_i0  <= r_idx[IDX_W-1:0];
        // A
        r_i1  <= r_i0;
        r_dx  <= {w_px[CW-1], w_px} - {r_qx[CW-1], r_qx};
        r_dy  <= {w_py[CW-1], w_py} - {r_qy[CW-1], r_qy};
        r_px  <= w_px;
        r_py  <= w_py;
        r_pz1 <= (w_px == '0) && (w_py == '0);
        r_hp1 <= !((!w_py[CW-1] && w_py != '0) || (w_py == '0 && !w_px[CW-1]));
        // B
        r_i2  <= r_i1;
        r_dx2 <= w_dx2[2*CW:0];
        r_dy2 <= w_dy2[2*CW:0];
        r_c1  <= w_c1;
        r_c2  <= w_c2;
        r_pz2 <= r_pz1;
        r_hp2 <= r_hp1;
        // C
        r_i3    <= r_i2;
        r_d3    <= w_d;
        r_pass3 <= w_pass;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found    <= 1'b0;
            r_best_idx <= '0;
        end else if (r_state == npag_pkg::S_Q_CNT) begin
            r_found    <= 1'b0;
            r_best_idx <= '0;
        end else if (r_v3 && r_pass3 && (!r_found || r_d3 < r_best_d)) begin
            r_found    <= 1'b1;
            r_best_idx <= r_i3;
            r_best_d   <= r_d3;
        end
    end

    // ------------------------------------------------------------------
    // Result
    // ------------------------------------------------------------------
    assign o_m_tvalid = (r_state == npag_pkg::S_OUT);
    assign o_m_tdata  = {(npag_pkg::M_TDATA_W - OW - 1)'(0),
                         r_found ? OW'(r_best_idx) : OW'(0),
                         r_found};

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `NPAG_ASSERT_NOW(a_none_zero_idx, o_m_tvalid && !o_m_tdata[0], o_m_tdata[OW:1] == '0,
        "result without a match carries a nonzero index")
    `NPAG_ASSERT_NOW(a_out_drained, o_m_tvalid, !w_pipe_busy,
        "result shown while points are still in flight")
    `NPAG_ASSERT_NOW(a_scan_bound, r_state == npag_pkg::S_SCAN,
        (r_idx <= r_cnt) && (r_cnt <= CNT_W'(MAX_POINTS)), "scan index past layer count")
    `NPAG_ASSERT_NXT(a_load_silent, w_s_acc && w_cmd == npag_pkg::CMD_LOAD, !o_m_tvalid,
        "load item produced a result")

endmodule

### rtl/npag_ram.sv
module npag_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 8192,
    parameter int AW    = 13
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

### tb/npag_checker.sv
module npag_checker #(
    parameter int MAX_POINTS = npag_pkg::DEF_MAX_POINTS,
    parameter int NUM_LAYERS = npag_pkg::DEF_NUM_LAYERS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_s_tvalid,
    input  logic                           i_s_tready,
    input  logic [npag_pkg::S_TDATA_W-1:0] i_s_tdata,  // layer, coord_x, coord_y, pad
    input  logic [npag_pkg::S_TUSER_W-1:0] i_s_tuser,  // command, first
    input  logic                           i_m_tvalid,
    input  logic                           i_m_tready,
    input  logic [npag_pkg::M_TDATA_W-1:0] i_m_tdata,  // found, point_index, pad
    output int                             o_errors,
    output int                             o_pending
);

    localparam int CW = npag_pkg::COORD_W;
    localparam int LW = npag_pkg::LAYER_W;
    localparam int OW = npag_pkg::OUT_IDX_W;

    typedef struct packed {
        logic          found;
        logic [OW-1:0] point_index;
    } t_answer;

    logic signed [CW-1:0] contour_x [NUM_LAYERS*MAX_POINTS];
    logic signed [CW-1:0] contour_y [NUM_LAYERS*MAX_POINTS];
    int unsigned          point_count [NUM_LAYERS];
    t_answer              pending_answers [$];

    // angle in [pi, 2pi)
    function automatic bit in_lower_half(longint x, longint y);
        return !(y > 0 || (y == 0 && x >= 0));
    endfunction

    // angle of P at or past angle of Q
    function automatic bit passes_gate(longint px, longint py, longint qx, longint qy);
        if (qx == 0 && qy == 0)
            return 1'b1;
        if (px == 0 && py == 0)
            return (qy == 0 && qx > 0);
        if (in_lower_half(px, py) != in_lower_half(qx, qy))
            return in_lower_half(px, py);
        return (qx * py - qy * px) >= 0;
    endfunction

    function automatic t_answer nearest_gated(int unsigned layer, longint qx, longint qy);
        t_answer     ans;
        longint      px, py, dx, dy, sq_dist, best;
        int unsigned base;
        ans  = '0;
        best = 0;
        if (layer < NUM_LAYERS) begin
            base = layer * MAX_POINTS;
            for (int unsigned i = 0; i < point_count[layer]; i++) begin
                px      = contour_x[base + i];
                py      = contour_y[base + i];
                dx      = px - qx;
                dy      = py - qy;
                sq_dist = dx * dx + dy * dy;
                // strict compare: ties keep the earlier index
                if ((!ans.found || sq_dist < best) && passes_gate(px, py, qx, qy)) begin
                    ans.found       = 1'b1;
                    ans.point_index = i[OW-1:0];
                    best            = sq_dist;
                end
            end
        end
        return ans;
    endfunction

    always @(posedge i_clk) begin : watch
        t_answer              want, got;
        logic [LW-1:0]        lay;
        logic signed [CW-1:0] x, y;
        if (!i_rst_n) begin
            foreach (point_count[k])
                point_count[k] = 0;
            pending_answers.delete();
            o_errors = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                got.found       = i_m_tdata[0];
                got.point_index = i_m_tdata[OW:1];
                if (pending_answers.size() == 0) begin
                    o_errors++;
                    $display("%0t: unexpected result, expected none, got found=%0d index=%0d",
                             $time, got.found, got.point_index);
                end else begin
                    want = pending_answers.pop_front();
                    if (got.found !== want.found) begin
                        o_errors++;
                        $display("%0t: found mismatch, expected %0d, got %0d",
                                 $time, want.found, got.found);
                    end
                    if (got.point_index !== want.point_index) begin
                        o_errors++;
                        $display("%0t: point_index mismatch, expected %0d, got %0d",
                                 $time, want.point_index, got.point_index);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                lay = i_s_tdata[LW-1:0];
                x   = i_s_tdata[LW +: CW];
                y   = i_s_tdata[LW+CW +: CW];
                if (i_s_tuser[0] == npag_pkg::CMD_LOAD) begin
                    if (lay < NUM_LAYERS) begin
                        if (i_s_tuser[1])
                            point_count[lay] = 0;
                        // full layer drops the point
                        if (point_count[lay] < MAX_POINTS) begin
                            contour_x[lay * MAX_POINTS + point_count[lay]] = x;
                            contour_y[lay * MAX_POINTS + point_count[lay]] = y;
                            point_count[lay]++;
                        end
                    end
                end else begin
                    pending_answers = {pending_answers, nearest_gated(lay, x, y)};
                end
            end
        end
        o_pending = pending_answers.size();
    end

endmodule

### tb/tb.sv
module tb;

    localparam int CW = npag_pkg::COORD_W;
    localparam int LW = npag_pkg::LAYER_W;

    // stimulus stops once this many items have gone in
    localparam int ITEM_TARGET = 1170;
    // sender runs without gaps for this window of item numbers
    localparam int CALM_FIRST  = 600;
    localparam int CALM_LAST   = 800;
    // layer that gets filled past capacity once
    localparam logic [LW-1:0] BIG_LAYER = 4'd15;

    localparam logic signed [CW-1:0] C_MAX = 24'sh7FFFFF;
    localparam logic signed [CW-1:0] C_MIN = 24'sh800000;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           i_s_tvalid;
    logic                           o_s_tready;
    // [3:0] layer, [27:4] x, [51:28] y, [55:52] zero
    logic [npag_pkg::S_TDATA_W-1:0] i_s_tdata;
    logic [npag_pkg::S_TUSER_W-1:0] i_s_tuser;   // [0] command, [1] first
    logic                           o_m_tvalid;
    logic                           i_m_tready;
    // [0] found, [9:1] point_index, [15:10] zero
    logic [npag_pkg::M_TDATA_W-1:0] o_m_tdata;
    int                             mismatch_count;
    int                             answers_owed;
    int                             items_sent;

    nearest_point_with_angle_gate dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    npag_checker checker_i (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .i_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .i_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .i_m_tdata  (o_m_tdata),
        .o_errors   (mismatch_count),
        .o_pending  (answers_owed)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop, late enough that even all-full-layer traffic fits.
    initial begin
        #32_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    // Result side: ~9% random stalls, a calm window with tready pinned high,
    // and one long hold-off started while a result is waiting so the block
    // stays busy and backs up the input side.
    initial begin : result_sink
        int cyc;
        int hold_left;
        bit held;
        i_m_tready = 1'b0;
        cyc        = 0;
        hold_left  = 0;
        held       = 1'b0;
        forever begin
            @(negedge i_clk);
            cyc++;
            if (!held && cyc >= 1500 && o_m_tvalid) begin
                held      = 1'b1;
                hold_left = 400;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_m_tready <= 1'b0;
            end else if (cyc >= 6000 && cyc < 9000) begin
                i_m_tready <= 1'b1;
            end else begin
                i_m_tready <= ($urandom_range(0, 99) >= 9);
            end
        end
    end

    // Mix of full-range, small (ties, near-origin), and extreme values.
    function automatic logic signed [CW-1:0] rand_coord();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return CW'($urandom);
            4, 5, 6:    return CW'(int'($urandom_range(0, 64)) - 32);
            7:          return '0;
            8:          return $urandom_range(0, 1) ? C_MIN : C_MAX;
            default:    return $urandom_range(0, 1) ? -24'sd1 : 24'sd1;
        endcase
    endfunction

    // Called at a falling edge, returns at the falling edge after acceptance.
    // tvalid gets at most one assignment per falling edge.
    task automatic send_item(logic cmd, logic [LW-1:0] layer, logic first,
                             logic signed [CW-1:0] x,
                             logic signed [CW-1:0] y);
        while ((items_sent < CALM_FIRST || items_sent >= CALM_LAST) &&
               $urandom_range(0, 99) < 9) begin
            i_s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {4'b0, y, x, layer};
        i_s_tuser  <= {first, cmd};
        do
            @(posedge i_clk);
        while (!o_s_tready);
        items_sent++;
        @(negedge i_clk);
    endtask

    initial begin : stimulus
        logic signed [CW-1:0] cx [32];
        logic signed [CW-1:0] cy [32];
        logic signed [CW-1:0] qx, qy;
        logic [LW-1:0]        lay;
        int                   n, pick, drain;
        bit                   big_done;

        i_rst_n    = 1'b0;
        i_s_tvalid = 1'b0;
        i_s_tdata  = '0;
        i_s_tuser  = '0;
        items_sent = 0;
        big_done   = 1'b0;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed ----
        // layer 0: origin, axis points, extremes, a point just into the
        // lower half, and a duplicate for the tie rule
        send_item(npag_pkg::CMD_LOAD, 4'd0, 1'b1, 24'sd0, 24'sd0);
        send_item(npag_pkg::CMD_LOAD, 4'd0, 1'b0, C_MAX, 24'sd0);
        send_item(npag_pkg::CMD_LOAD, 4'd0, 1'b0, 24'sd0, C_MAX);
        send_item(npag_pkg::CMD_LOAD, 4'd0, 1'b0, C_MIN, C_MIN);
        send_item(npag_pkg::CMD_LOAD, 4'd0, 1'b0, -24'sd1, 24'sd0);
        send_item(npag_pkg::CMD_LOAD, 4'd0, 1'b0, C_MAX, -24'sd1);
        send_item(npag_pkg::CMD_LOAD, 4'd0, 1'b0, C_MAX, 24'sd0);
        // query at origin lets all pass; +X axis lets the stored origin pass
        send_item(npag_pkg::CMD_QUERY, 4'd0, 1'b0, 24'sd0, 24'sd0);
        send_item(npag_pkg::CMD_QUERY, 4'd0, 1'b0, 24'sd1, 24'sd0);
        send_item(npag_pkg::CMD_QUERY, 4'd0, 1'b0, 24'sd0, 24'sd1);
        send_item(npag_pkg::CMD_QUERY, 4'd0, 1'b0, -24'sd1, 24'sd0);
        send_item(npag_pkg::CMD_QUERY, 4'd0, 1'b0, 24'sd0, -24'sd1);
        send_item(npag_pkg::CMD_QUERY, 4'd0, 1'b0, C_MIN, C_MIN);
        send_item(npag_pkg::CMD_QUERY, 4'd0, 1'b0, C_MAX, C_MAX);
        // tie between index 1 and 6; first flag on a query is ignored
        send_item(npag_pkg::CMD_QUERY, 4'd0, 1'b1, C_MAX, 24'sd0);
        // never-loaded layer
        send_item(npag_pkg::CMD_QUERY, 4'd9, 1'b0, 24'sd3, 24'sd3);
        // lone upper-half point vs lower-half query: nothing passes
        send_item(npag_pkg::CMD_LOAD, 4'd2, 1'b1, 24'sd5, 24'sd5);
        send_item(npag_pkg::CMD_QUERY, 4'd2, 1'b0, -24'sd5, -24'sd5);
        send_item(npag_pkg::CMD_QUERY, 4'd2, 1'b0, 24'sd5, 24'sd5);
        // widest possible distance
        send_item(npag_pkg::CMD_LOAD, 4'd1, 1'b1, C_MIN, C_MAX);
        send_item(npag_pkg::CMD_QUERY, 4'd1, 1'b0, C_MAX, C_MIN);

        // ---- random ----
        while (items_sent < ITEM_TARGET) begin
            pick = $urandom_range(0, 99);
            if (!big_done && items_sent > 250) begin
                // overfill one layer, query it, then restart it and query it again
                big_done = 1'b1;
                for (int k = 0; k < npag_pkg::DEF_MAX_POINTS + 4; k++)
                    send_item(npag_pkg::CMD_LOAD, BIG_LAYER, k == 0,
                              rand_coord(), rand_coord());
                repeat (3)
                    send_item(npag_pkg::CMD_QUERY, BIG_LAYER, 1'b0,
                              rand_coord(), rand_coord());
                send_item(npag_pkg::CMD_QUERY, BIG_LAYER, 1'b0, 24'sd0, 24'sd0);
                send_item(npag_pkg::CMD_LOAD, BIG_LAYER, 1'b1, rand_coord(), rand_coord());
                send_item(npag_pkg::CMD_QUERY, BIG_LAYER, 1'b0, rand_coord(), rand_coord());
            end else if (pick < 70) begin
                // well-formed contour, then queries, some seeded from its points
                lay = LW'($urandom_range(0, 15));
                n   = $urandom_range(1, 24);
                for (int k = 0; k < n; k++) begin
                    if (k > 0 && $urandom_range(0, 9) == 0) begin
                        cx[k] = cx[k-1];   // duplicate for ties
                        cy[k] = cy[k-1];
                    end else begin
                        cx[k] = rand_coord();
                        cy[k] = rand_coord();
                    end
                    send_item(npag_pkg::CMD_LOAD, lay, k == 0, cx[k], cy[k]);
                end
                repeat ($urandom_range(1, 6)) begin
                    pick = $urandom_range(0, n - 1);
                    case ($urandom_range(0, 5))
                        0: begin
                            qx = cx[pick];
                            qy = cy[pick];
                        end
                        1: begin
                            qx = CW'(int'(cx[pick]) + int'($urandom_range(0, 8)) - 4);
                            qy = CW'(int'(cy[pick]) + int'($urandom_range(0, 8)) - 4);
                        end
                        2, 3: begin
                            qx = rand_coord();
                            qy = rand_coord();
                        end
                        4: begin
                            qx = '0;
                            qy = '0;
                        end
                        default: begin
                            // on an axis, mostly positive X (angle zero)
                            qx = $urandom_range(0, 3) ? CW'($urandom_range(1, 1000))
                                                     : 24'sd0;
                            qy = (qx == 0) ? rand_coord() : 24'sd0;
                        end
                    endcase
                    send_item(npag_pkg::CMD_QUERY, lay, 1'($urandom_range(0, 1)), qx, qy);
                end
            end else if (pick < 82) begin
                // appends with no restart
                lay = LW'($urandom_range(0, 14));
                repeat ($urandom_range(1, 5))
                    send_item(npag_pkg::CMD_LOAD, lay, 1'b0, rand_coord(), rand_coord());
            end else begin
                // stray query, any layer
                send_item(npag_pkg::CMD_QUERY, LW'($urandom_range(0, 15)),
                          1'($urandom_range(0, 1)), rand_coord(), rand_coord());
            end
        end
        i_s_tvalid <= 1'b0;

        // drain, then a short tail for loads still in flight
        drain = 0;
        while (answers_owed != 0 && drain < 200_000) begin
            @(posedge i_clk);
            drain++;
        end
        repeat (50) @(posedge i_clk);

        if (mismatch_count == 0 && answers_owed == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
